// ===== rtl/msd_pkg.sv =====
// Shared types, message constants and the block-to-part lookup for the SysEx mode detector.
// Used by msd_tracker, msd_classify and midi_sysex_mode_detector; depends on nothing.
package msd_pkg;

	localparam int unsigned HeadDepth = 10;
	localparam logic [3:0]  CountMax  = 4'd15;

	// Manufacturer ids
	localparam logic [7:0] ID_UNIVERSAL = 8'h7E;
	localparam logic [7:0] ID_CHECKSUM  = 8'h41;
	localparam logic [7:0] ID_XG        = 8'h43;

	// Message body bytes
	localparam logic [7:0] EOX          = 8'hF7;
	localparam logic [7:0] SUB_GM       = 8'h09;
	localparam logic [7:0] GM_ON        = 8'h01;
	localparam logic [7:0] GM_OFF       = 8'h02;
	localparam logic [7:0] GM2_ON       = 8'h03;
	localparam logic [7:0] MODEL_GS     = 8'h42;
	localparam logic [7:0] CMD_SET      = 8'h12;
	localparam logic [7:0] ADDR_HI_GS   = 8'h40;
	localparam logic [7:0] ADDR_RESET   = 8'h7F;
	localparam logic [7:0] VAL_GS_RESET = 8'h41;
	localparam logic [7:0] ADDR_RHYTHM  = 8'h15;
	localparam logic [7:0] BLOCK_MASK   = 8'hF0;
	localparam logic [7:0] BLOCK_PART   = 8'h10;
	localparam logic [7:0] MODEL_XG     = 8'h4C;
	localparam logic [7:0] XG_RESET_VAL = 8'h7E;
	localparam logic [7:0] BYTE_ZERO    = 8'h00;
	localparam logic [7:0] MODE_MAX     = 8'h02;

	typedef enum logic [2:0] {
		OUT_NONE       = 3'd0,
		OUT_GM_ON      = 3'd1,
		OUT_GM_OFF     = 3'd2,
		OUT_GM2_ON     = 3'd3,
		OUT_GS_RESET   = 3'd4,
		OUT_XG_RESET   = 3'd5,
		OUT_RHYTHM     = 3'd6,
		OUT_UNKNOWN_GM = 3'd7
	} outcome_t;

	// Per-message context held by the tracker.
	typedef struct packed {
		logic [HeadDepth-1:0][7:0] head;
		logic [3:0]                count;
		logic [7:0]                sum;
		logic [7:0]                prev1;
		logic [7:0]                prev2;
	} ctx_t;

	typedef struct packed {
		outcome_t   outcome;
		logic [3:0] part_channel;
		logic [1:0] part_mode;
		logic       bad_termination;
		logic       bad_checksum;
		logic       mode_out_of_range;
	} result_t;

	// Zero-based channel of the part addressed by a block number.
	function automatic logic [3:0] block_channel(input logic [3:0] blk);
		logic [3:0] ch;
		case (blk)
			4'd0:    ch = 4'd9;
			4'd1:    ch = 4'd0;
			4'd2:    ch = 4'd1;
			4'd3:    ch = 4'd2;
			4'd4:    ch = 4'd3;
			4'd5:    ch = 4'd4;
			4'd6:    ch = 4'd5;
			4'd7:    ch = 4'd6;
			4'd8:    ch = 4'd7;
			4'd9:    ch = 4'd8;
			4'd10:   ch = 4'd10;
			4'd11:   ch = 4'd11;
			4'd12:   ch = 4'd12;
			4'd13:   ch = 4'd13;
			4'd14:   ch = 4'd14;
			4'd15:   ch = 4'd15;
			default: ch = 4'd0;
		endcase
		return ch;
	endfunction

endpackage

// ===== rtl/msd_tracker.sv =====
// Per-message byte tracker: head bytes, saturating count, checksum sum and the last two bytes.
// Depends on msd_pkg.
module msd_tracker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    msg_byte,
	input  logic          end_of_msg,
	output msd_pkg::ctx_t ctx
);
	import msd_pkg::*;

	ctx_t ctx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q <= '0;
		end else if (step) begin
			if (end_of_msg) begin
				ctx_q <= '0;
			end else begin
				for (int k = 0; k < HeadDepth; k++) begin
					if (ctx_q.count == 4'(k)) begin
						ctx_q.head[k] <= msg_byte;
					end
				end
				// The sum trails the newest byte by two places and starts at index 4.
				if (ctx_q.count >= 4'd6) begin
					ctx_q.sum <= ctx_q.sum + ctx_q.prev2;
				end
				ctx_q.prev2 <= ctx_q.prev1;
				ctx_q.prev1 <= msg_byte;
				if (ctx_q.count != CountMax) begin
					ctx_q.count <= ctx_q.count + 4'd1;
				end
			end
		end
	end

	assign ctx = ctx_q;

endmodule

// ===== rtl/msd_classify.sv =====
// Classifies a message at its last byte from the tracker context and that byte.
// Depends on msd_pkg.
module msd_classify (
	input  msd_pkg::ctx_t    ctx,
	input  logic [7:0]       msg_byte,
	output msd_pkg::result_t result
);
	import msd_pkg::*;

	logic [HeadDepth-1:0][7:0] msg;
	logic [3:0]                idx;
	logic [7:0]                sum;
	logic [6:0]                expect_sum;

	always_comb begin
		idx = ctx.count;
		for (int k = 0; k < HeadDepth; k++) begin
			msg[k] = (idx == 4'(k)) ? msg_byte : ctx.head[k];
		end
		sum        = ctx.sum + ((idx >= 4'd6) ? ctx.prev2 : 8'd0);
		expect_sum = 7'd0 - sum[6:0];
	end

	always_comb begin
		result = '0;
		result.outcome = OUT_NONE;
		if (msg[0] == ID_UNIVERSAL) begin
			if (idx >= 4'd3 && msg[2] == SUB_GM) begin
				if (msg[3] == GM_ON) begin
					result.outcome = OUT_GM_ON;
				end else if (msg[3] == GM_OFF) begin
					result.outcome = OUT_GM_OFF;
				end else if (msg[3] == GM2_ON) begin
					result.outcome = OUT_GM2_ON;
				end else begin
					result.outcome = OUT_UNKNOWN_GM;
				end
				result.bad_termination = (idx >= 4'd4) && (msg[4] != EOX);
			end
		end else if (msg[0] == ID_CHECKSUM) begin
			if (idx >= 4'd2) begin
				result.bad_termination = (msg_byte != EOX);
				if (ctx.prev1 != {1'b0, expect_sum}) begin
					result.bad_checksum = 1'b1;
				end else if (idx == 4'd9 && msg[2] == MODEL_GS && msg[3] == CMD_SET &&
				             msg[4] == ADDR_HI_GS && msg[9] == EOX) begin
					if (msg[5] == BYTE_ZERO && msg[6] == ADDR_RESET && msg[7] == BYTE_ZERO &&
					    msg[8] == VAL_GS_RESET) begin
						result.outcome = OUT_GS_RESET;
					end else if (msg[6] == ADDR_RHYTHM &&
					             (msg[5] & BLOCK_MASK) == BLOCK_PART) begin
						if (msg[7] > MODE_MAX) begin
							result.mode_out_of_range = 1'b1;
						end else begin
							result.outcome      = OUT_RHYTHM;
							result.part_channel = block_channel(msg[5][3:0]);
							result.part_mode    = msg[7][1:0];
						end
					end
				end
			end
		end else if (msg[0] == ID_XG) begin
			if (idx == 4'd7 && msg[2] == MODEL_XG && msg[3] == BYTE_ZERO &&
			    msg[4] == BYTE_ZERO && msg[5] == XG_RESET_VAL && msg[6] == BYTE_ZERO &&
			    msg[7] == EOX) begin
				result.outcome = OUT_XG_RESET;
			end
		end
	end

endmodule

// ===== rtl/midi_sysex_mode_detector.sv =====
// Top level of the SysEx mode detector: input register, tracker, classifier, result register.
// Depends on msd_pkg, msd_tracker and msd_classify.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-------------------------------------------------------
//  in      | in_valid / in_ready  | msg_byte[7:0], end_of_msg
//  out     | out_valid / out_ready| outcome[2:0], part_channel[3:0], part_mode[1:0],
//          |                      | bad_termination, bad_checksum, mode_out_of_range
//
// One item is accepted per cycle while in_ready is high; a result is registered when its last
// byte leaves the input stage. The rate is set by the single input stage, which updates the
// tracker and classifies as it advances. Reset clears the stage valid bits and the per-message
// context at once. A non-final byte leaves the input stage even while a result waits at the
// output; only a final byte waits for the result register to free, and then in_ready falls.
module midi_sysex_mode_detector (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] msg_byte,
	input  logic       end_of_msg,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] outcome,
	output logic [3:0] part_channel,
	output logic [1:0] part_mode,
	output logic       bad_termination,
	output logic       bad_checksum,
	output logic       mode_out_of_range
);
	import msd_pkg::*;

	// Input stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       adv_s1;

	// Result register.
	logic    out_valid_q;
	result_t result_q;

	ctx_t    ctx;
	result_t result;

	// The stage moves on unless it holds a final byte whose result has nowhere to go.
	assign adv_s1   = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= msg_byte;
			last_s1 <= end_of_msg;
		end
	end

	msd_tracker u_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv_s1),
		.msg_byte   (byte_s1),
		.end_of_msg (last_s1),
		.ctx        (ctx)
	);

	msd_classify u_classify (
		.ctx      (ctx),
		.msg_byte (byte_s1),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			result_q <= result;
		end
	end

	assign out_valid         = out_valid_q;
	assign outcome           = result_q.outcome;
	assign part_channel      = result_q.part_channel;
	assign part_mode         = result_q.part_mode;
	assign bad_termination   = result_q.bad_termination;
	assign bad_checksum      = result_q.bad_checksum;
	assign mode_out_of_range = result_q.mode_out_of_range;

	// An empty input stage always takes an item.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stage empty but not ready");

	// A rhythm mode result never carries a mode above two.
	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_q.outcome == OUT_RHYTHM) |-> (result_q.part_mode != 2'd3))
		else $error("rhythm mode result with mode out of range");

	// Channel and mode are zero for every other outcome.
	a_part_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_q.outcome != OUT_RHYTHM) |->
		(result_q.part_channel == 4'd0 && result_q.part_mode == 2'd0))
		else $error("part fields set on a non-rhythm result");

	// A failed checksum or a rejected mode gives no outcome.
	a_flag_no_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (result_q.bad_checksum || result_q.mode_out_of_range)) |->
		(result_q.outcome == OUT_NONE))
		else $error("outcome reported alongside checksum or mode error");

	// The context is back to its cleared state after a final byte leaves the stage.
	a_ctx_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> (ctx.count == 4'd0 && ctx.sum == 8'd0))
		else $error("message context not cleared after final byte");

endmodule

// ===== tb/midi_sysex_mode_detector_test.sv =====
// Self-checking testbench for the SysEx mode detector: directed frames, then random frames.
// Depends on msd_pkg and midi_sysex_mode_detector; the scoreboard class predicts every verdict.
module midi_sysex_mode_detector_test;
	timeunit 1ns;
	timeprecision 1ps;

	import msd_pkg::*;

	// The scoreboard keeps its own copy of the per-message context. It is updated on
	// every accepted byte, and a verdict is predicted when the final byte of a frame
	// goes in.
	class mode_scoreboard;
		logic [7:0] head[10];
		logic [3:0] count;
		logic [7:0] sum;
		logic [7:0] prev1;
		logic [7:0] prev2;
		result_t    awaited_verdicts[$];
		int         errors;
		int         verdicts;
		int         seen[8];
		int         flag_term;
		int         flag_sum;
		int         flag_range;

		function new();
			errors = 0;
			verdicts = 0;
			flag_term = 0;
			flag_sum = 0;
			flag_range = 0;
			foreach (seen[i])
				seen[i] = 0;
			clear_context();
		endfunction

		function void clear_context();
			foreach (head[i])
				head[i] = 8'h00;
			count = 4'd0;
			sum = 8'h00;
			prev1 = 8'h00;
			prev2 = 8'h00;
		endfunction

		function int pending();
			return awaited_verdicts.size();
		endfunction

		// Notes one accepted byte and, on the final byte, queues the predicted verdict.
		function void take_byte(input logic [7:0] b, input logic last);
			logic [7:0]  m[10];
			int unsigned idx;
			int unsigned len;
			logic [7:0]  s;
			logic [7:0]  want;
			logic [3:0]  blk;
			result_t     r;
			idx = count;
			if (!last) begin
				if (idx < 10)
					head[idx] = b;
				// The checksum trails the newest byte by two, so the check byte and
				// the terminator are never summed.
				if (idx >= 6)
					sum = sum + prev2;
				prev2 = prev1;
				prev1 = b;
				if (count != CountMax)
					count = count + 4'd1;
				return;
			end
			m = head;
			if (idx < 10)
				m[idx] = b;
			len = idx + 1;
			r = '0;
			r.outcome = OUT_NONE;
			if (m[0] == ID_UNIVERSAL) begin
				if (len >= 4 && m[2] == SUB_GM) begin
					if (m[3] == GM_ON)
						r.outcome = OUT_GM_ON;
					else if (m[3] == GM_OFF)
						r.outcome = OUT_GM_OFF;
					else if (m[3] == GM2_ON)
						r.outcome = OUT_GM2_ON;
					else
						r.outcome = OUT_UNKNOWN_GM;
					// Termination is only judged when a fifth byte exists.
					if (len > 4 && m[4] != EOX)
						r.bad_termination = 1'b1;
				end
			end else if (m[0] == ID_CHECKSUM) begin
				if (len >= 3) begin
					s = sum;
					if (b != EOX)
						r.bad_termination = 1'b1;
					if (len >= 7)
						s = s + prev2;
					want = (8'h80 - (s & 8'h7F)) & 8'h7F;
					if (prev1 != want) begin
						r.bad_checksum = 1'b1;
					end else if (len == 10 && m[2] == MODEL_GS && m[3] == CMD_SET &&
							m[4] == ADDR_HI_GS && m[9] == EOX) begin
						if (m[5] == BYTE_ZERO && m[6] == ADDR_RESET && m[7] == BYTE_ZERO &&
								m[8] == VAL_GS_RESET) begin
							r.outcome = OUT_GS_RESET;
						end else if (m[6] == ADDR_RHYTHM &&
								(m[5] & BLOCK_MASK) == BLOCK_PART) begin
							if (m[7] > MODE_MAX) begin
								r.mode_out_of_range = 1'b1;
							end else begin
								// Block 0 addresses the tenth part; blocks 1 to 9
								// are shifted down by one; the rest map straight.
								blk = m[5][3:0];
								r.outcome = OUT_RHYTHM;
								r.part_channel = (blk == 4'd0) ? 4'd9 :
									(blk <= 4'd9) ? blk - 4'd1 : blk;
								r.part_mode = m[7][1:0];
							end
						end
					end
				end
			end else if (m[0] == ID_XG) begin
				if (len == 8 && m[2] == MODEL_XG && m[3] == BYTE_ZERO && m[4] == BYTE_ZERO &&
						m[5] == XG_RESET_VAL && m[6] == BYTE_ZERO && m[7] == EOX)
					r.outcome = OUT_XG_RESET;
			end
			awaited_verdicts.push_back(r);
			clear_context();
		endfunction

		// Compares one result from the block with the oldest predicted verdict.
		function void check_verdict(input logic [2:0] oc, input logic [3:0] ch,
				input logic [1:0] md, input logic bt, input logic bs, input logic mr);
			result_t want;
			if (awaited_verdicts.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("Result with nothing awaited: %0d/%0d/%0d/%b%b%b",
						oc, ch, md, bt, bs, mr);
				return;
			end
			want = awaited_verdicts.pop_front();
			verdicts++;
			seen[want.outcome]++;
			flag_term += want.bad_termination;
			flag_sum += want.bad_checksum;
			flag_range += want.mode_out_of_range;
			if (want.outcome != oc || want.part_channel != ch || want.part_mode != md ||
					want.bad_termination != bt || want.bad_checksum != bs ||
					want.mode_out_of_range != mr) begin
				errors++;
				if (errors <= 10)
					$display("Verdict %0d: expected %0d/%0d/%0d/%b%b%b, got %0d/%0d/%0d/%b%b%b",
						verdicts, want.outcome, want.part_channel, want.part_mode,
						want.bad_termination, want.bad_checksum, want.mode_out_of_range,
						oc, ch, md, bt, bs, mr);
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] msg_byte = 8'h00;
	logic       end_of_msg = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [2:0] outcome;
	logic [3:0] part_channel;
	logic [1:0] part_mode;
	logic       bad_termination;
	logic       bad_checksum;
	logic       mode_out_of_range;

	mode_scoreboard sb = new();

	// The frame under construction; the builders below fill it and send_frame empties it.
	logic [7:0] frame[$];
	int         burst_left = 0;
	int         bytes_sent = 0;
	int         frames_sent = 0;
	logic [15:0] stall_pat = 16'hFFFF;
	int          stall_left = 0;

	midi_sysex_mode_detector uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.msg_byte          (msg_byte),
		.end_of_msg        (end_of_msg),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.outcome           (outcome),
		.part_channel      (part_channel),
		.part_mode         (part_mode),
		.bad_termination   (bad_termination),
		.bad_checksum      (bad_checksum),
		.mode_out_of_range (mode_out_of_range)
	);

	always #1 clk = ~clk;

	// Both channels are observed at the rising edge, where the values seen are those
	// that were settled before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.take_byte(msg_byte, end_of_msg);
			if (out_valid && out_ready)
				sb.check_verdict(outcome, part_channel, part_mode, bad_termination,
					bad_checksum, mode_out_of_range);
		end
	end

	// The receiver rotates a 16-bit ready pattern and picks a fresh one when a random countdown
	// runs out. Some patterns are all ones, giving stretches with no back-pressure at all;
	// bit 0 is always set so that a stall never lasts a whole turn of the pattern.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_left = $urandom_range(24, 96);
			case ($urandom_range(0, 3))
				0: stall_pat = 16'hFFFF;
				1: stall_pat = 16'($urandom);
				2: stall_pat = 16'($urandom) | 16'($urandom);
				default: stall_pat = 16'($urandom) & 16'($urandom);
			endcase
			stall_pat[0] = 1'b1;
		end
		stall_left--;
		stall_pat = {stall_pat[14:0], stall_pat[15]};
		out_ready <= stall_pat[0];
	end

	// Offers one byte and holds it until it is taken. The sender works in bursts; when a
	// burst runs out, valid drops and a new burst length is drawn before the byte is offered.
	task automatic send_byte(input logic [7:0] b, input logic last);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) :
				$urandom_range(1, 24);
		end
		in_valid <= 1'b1;
		msg_byte <= b;
		end_of_msg <= last;
		do
			@(posedge clk);
		while (!in_ready);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_frame();
		foreach (frame[i])
			send_byte(frame[i], i == frame.size() - 1);
		frames_sent++;
	endtask

	// Writes the seven-bit check byte over bytes 4 to length-3 into byte length-2.
	function automatic void seal_checksum();
		logic [7:0] s;
		s = 8'h00;
		for (int i = 4; i <= frame.size() - 3; i++)
			s = s + frame[i];
		frame[frame.size() - 2] = (8'h80 - (s & 8'h7F)) & 8'h7F;
	endfunction

	// A universal frame: id, device, sub-id, command, then an optional tail whose first
	// byte is the given terminator.
	function automatic void build_gm(input logic [7:0] sub_id, input logic [7:0] cmd,
			input int tail, input logic [7:0] term);
		frame.delete();
		frame.push_back(ID_UNIVERSAL);
		frame.push_back(8'($urandom));
		frame.push_back(sub_id);
		frame.push_back(cmd);
		if (tail > 0)
			frame.push_back(term);
		for (int i = 1; i < tail; i++)
			frame.push_back(8'($urandom));
	endfunction

	// A ten-byte checksummed parameter set at address 40 a5 a6 with value a7.
	function automatic void build_gs(input logic [7:0] a5, input logic [7:0] a6,
			input logic [7:0] a7, input logic good_sum, input logic [7:0] term);
		frame.delete();
		frame.push_back(ID_CHECKSUM);
		frame.push_back(8'($urandom));
		frame.push_back(MODEL_GS);
		frame.push_back(CMD_SET);
		frame.push_back(ADDR_HI_GS);
		frame.push_back(a5);
		frame.push_back(a6);
		frame.push_back(a7);
		frame.push_back(8'h00);
		frame.push_back(term);
		seal_checksum();
		if (!good_sum)
			frame[8] = frame[8] ^ 8'($urandom_range(1, 127));
	endfunction

	function automatic void build_xg();
		frame.delete();
		frame.push_back(ID_XG);
		frame.push_back(8'($urandom));
		frame.push_back(MODEL_XG);
		frame.push_back(BYTE_ZERO);
		frame.push_back(BYTE_ZERO);
		frame.push_back(XG_RESET_VAL);
		frame.push_back(BYTE_ZERO);
		frame.push_back(EOX);
	endfunction

	// A checksummed frame of any length with random body and a correct check byte; long
	// ones drive the byte counter into saturation.
	function automatic void build_long_sum(input int len);
		frame.delete();
		frame.push_back(ID_CHECKSUM);
		for (int i = 1; i < len - 1; i++)
			frame.push_back(8'($urandom));
		frame.push_back(EOX);
		seal_checksum();
	endfunction

	function automatic void build_noise(input int len, input logic [7:0] fill, input logic rnd);
		frame.delete();
		for (int i = 0; i < len; i++)
			frame.push_back(rnd ? 8'($urandom) : fill);
		if (rnd) begin
			case ($urandom_range(0, 3))
				0: frame[0] = ID_UNIVERSAL;
				1: frame[0] = ID_CHECKSUM;
				2: frame[0] = ID_XG;
				default: ;
			endcase
		end
	endfunction

	initial begin
		int         kind;
		int unsigned cut;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames: every outcome, every flag and the length corner cases.
		build_gm(SUB_GM, GM_ON, 1, EOX);            send_frame();
		build_gm(SUB_GM, GM_OFF, 1, EOX);           send_frame();
		build_gm(SUB_GM, GM2_ON, 1, EOX);           send_frame();
		build_gm(SUB_GM, 8'h7F, 1, EOX);            send_frame();
		build_gm(SUB_GM, GM_ON, 0, EOX);            send_frame(); // four bytes, no terminator
		build_gm(SUB_GM, GM_OFF, 1, 8'h00);         send_frame(); // bad termination
		build_gm(8'h08, GM_ON, 1, EOX);             send_frame(); // unknown sub-id
		build_gm(SUB_GM, GM_ON, 0, EOX);
		void'(frame.pop_back());                    send_frame(); // too short
		build_gs(BYTE_ZERO, ADDR_RESET, BYTE_ZERO, 1'b1, EOX); send_frame();
		build_gs(8'h10, ADDR_RHYTHM, 8'h00, 1'b1, EOX); send_frame();
		build_gs(8'h19, ADDR_RHYTHM, 8'h01, 1'b1, EOX); send_frame();
		build_gs(8'h1F, ADDR_RHYTHM, 8'h02, 1'b1, EOX); send_frame();
		build_gs(8'h12, ADDR_RHYTHM, 8'h03, 1'b1, EOX); send_frame(); // mode out of range
		build_gs(8'h1A, ADDR_RHYTHM, 8'h7F, 1'b1, EOX); send_frame();
		build_gs(8'h11, ADDR_RHYTHM, 8'h01, 1'b0, EOX); send_frame(); // bad checksum
		build_gs(8'h11, ADDR_RHYTHM, 8'h01, 1'b1, 8'hFF); send_frame(); // bad termination
		build_xg();                                 send_frame();
		build_xg();
		frame.insert(7, 8'h00);                     send_frame(); // one byte too long
		build_long_sum(3);                          send_frame(); // shortest checksummed
		build_long_sum(6);                          send_frame(); // empty checksum range
		build_long_sum(22);                         send_frame(); // counter saturates
		build_noise(2, ID_CHECKSUM, 1'b0);          send_frame(); // checksummed, too short
		build_noise(1, 8'hFF, 1'b0);                send_frame();
		build_noise(18, 8'h00, 1'b0);               send_frame();
		build_noise(12, 8'hFF, 1'b0);               send_frame();

		// Random frames. Most are well formed with random content so that the deeper
		// matches are reached; a share is mangled or cut short, and the rest is noise.
		while (bytes_sent < 1200) begin
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				if ($urandom_range(0, 6) == 0)
					build_gs(BYTE_ZERO, ADDR_RESET, BYTE_ZERO, $urandom_range(0, 9) != 0,
						($urandom_range(0, 14) != 0) ? EOX : 8'($urandom));
				else
					build_gs(($urandom_range(0, 4) != 0) ? {4'h1, 4'($urandom)} : 8'($urandom),
						($urandom_range(0, 6) != 0) ? ADDR_RHYTHM : 8'($urandom),
						($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom),
						$urandom_range(0, 9) != 0,
						($urandom_range(0, 14) != 0) ? EOX : 8'($urandom));
			end else if (kind < 60) begin
				build_gm(($urandom_range(0, 7) != 0) ? SUB_GM : 8'($urandom),
					($urandom_range(0, 4) != 0) ? 8'($urandom_range(1, 3)) : 8'($urandom),
					$urandom_range(0, 3),
					($urandom_range(0, 5) != 0) ? EOX : 8'($urandom));
			end else if (kind < 72) begin
				build_xg();
			end else if (kind < 82) begin
				build_long_sum(($urandom_range(0, 2) == 0) ? $urandom_range(11, 24) :
					$urandom_range(3, 10));
			end else begin
				build_noise($urandom_range(1, 20), 8'h00, 1'b1);
			end
			// Corrupt or shorten some of the well-formed frames.
			if (kind < 82 && $urandom_range(0, 9) == 0)
				frame[$urandom_range(1, frame.size() - 1)] = 8'($urandom);
			if (kind < 82 && $urandom_range(0, 19) == 0) begin
				cut = $urandom_range(1, frame.size() - 1);
				while (frame.size() > cut)
					void'(frame.pop_back());
			end
			send_frame();
		end
		in_valid <= 1'b0;

		// Step past the edge that took the last byte, so its verdict is already queued.
		do
			@(posedge clk);
		while (sb.pending() != 0);
		repeat (8) @(posedge clk);

		$display("Covered %0d bytes in %0d frames, %0d verdicts: none %0d, GM on/off/GM2 %0d/%0d/%0d,",
			bytes_sent, frames_sent, sb.verdicts, sb.seen[OUT_NONE], sb.seen[OUT_GM_ON],
			sb.seen[OUT_GM_OFF], sb.seen[OUT_GM2_ON]);
		$display("GS %0d, XG %0d, rhythm %0d, unknown GM %0d; flags term/sum/mode %0d/%0d/%0d.",
			sb.seen[OUT_GS_RESET], sb.seen[OUT_XG_RESET], sb.seen[OUT_RHYTHM],
			sb.seen[OUT_UNKNOWN_GM], sb.flag_term, sb.flag_sum, sb.flag_range);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog: a correct run needs well under a tenth of this.
	initial begin
		#2000000;
		$display("Timed out with %0d verdicts still awaited", sb.pending());
		$display("Some tests failed");
		$finish;
	end

endmodule
